// File: rtl/lens_distortion_scale_top_defines.svh
// assertion macros for the checker file of the lens distortion scale block
`ifndef LENS_DISTORTION_SCALE_TOP_DEFINES_SVH
`define LENS_DISTORTION_SCALE_TOP_DEFINES_SVH

// same-cycle implication, ignored while in reset
`define LDS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lds assertion failed");

// next-cycle implication, ignored while in reset
`define LDS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lds assertion failed");

// next-cycle implication that also holds across reset
`define LDS_ASSERT_RST(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("lds reset assertion failed");

`endif

// File: rtl/lds_pkg.sv
// types, codes and saturation helper shared by the lens distortion scale block
`default_nettype none
package lds_pkg;

  typedef logic signed [31:0] fix_t;

  typedef struct packed {
    logic ovf;
    fix_t val;
  } satres_t;

  // one queued beat after classification
  typedef struct packed {
    logic        load;
    logic [3:0]  idx;
    fix_t        val;
    logic [30:0] rsq;
  } item_t;

  // configuration registers as seen by the datapath
  typedef struct packed {
    logic [1:0]  eq;
    fix_t        off;
    fix_t        slope;
    logic [30:0] spr;
  } cfg_t;

  // per-item sideband through the divider stages
  typedef struct packed {
    logic        vld;
    logic        recip;
    logic        zero;
    logic        neg;
    logic        big;
    logic [31:0] mag;
    fix_t        base;
    logic        bovf;
    fix_t        fac;
    logic        ova;
  } tail_t;

  typedef struct packed {
    fix_t r;
    fix_t fac;
    logic ova;
  } carry_t;

  localparam logic [1:0] EQ_QUARTIC = 2'd0;
  localparam logic [1:0] EQ_RECIP   = 2'd1;
  localparam logic [1:0] EQ_SPLINE  = 2'd2;
  localparam logic [1:0] EQ_UNITY   = 2'd3;

  localparam logic MODE_EVAL = 1'b0;
  localparam logic MODE_LOAD = 1'b1;

  localparam logic [1:0] CFG_EQ_TYPE  = 2'd0;
  localparam logic [1:0] CFG_AB_OFF   = 2'd1;
  localparam logic [1:0] CFG_AB_SLOPE = 2'd2;
  localparam logic [1:0] CFG_SEG_PER  = 2'd3;

  localparam int QDEPTH = 4;
  localparam int QPW    = 2;

  localparam int IN_TDATA_W  = 72;
  localparam int OUT_TDATA_W = 32;

  function automatic satres_t sat64(input logic signed [63:0] v);
    satres_t s;
    if (v > 64'sd2147483647) begin
      s.ovf = 1'b1;
      s.val = 32'sh7fffffff;
    end else if (v < -64'sd2147483648) begin
      s.ovf = 1'b1;
      s.val = 32'sh80000000;
    end else begin
      s.ovf = 1'b0;
      s.val = v[31:0];
    end
    return s;
  endfunction

endpackage
`default_nettype wire

// File: rtl/lens_distortion_scale_top.sv
// top level of the lens distortion scale block: ports, config registers, front and back
// usage
//   in_* is a stream of items: in_tuser = 0 asks for the scale of in_tdata's squared
//   radius, in_tuser = 1 writes one spline/polynomial coefficient and gives no beat out
//   out_* carries one beat per evaluation, in the order the items came in:
//   out_tdata = scale (signed q8.24), out_tuser = overflow (saturation or zero divisor)
//   cfg_* writes the equation type, aberration terms and segment density; cfg_ready
//   is always high and writes belong to times when no item is in flight
// timing
//   one item per cycle sustained while out_tready stays high; an evaluation passes the
//   queue, the 9-stage equation pipe, the 32-stage reciprocal divider (one quotient
//   bit per stage) and two final stages
//   a coefficient load takes effect for every item accepted after it
// reset
//   rst_n is synchronous; the queue and all pipe valids clear, config returns to
//   spline with no aberration and 10 segments per unit squared radius; the table
//   holds whatever it held until written
// stall
//   a low out_tready while out_tvalid is high freezes the whole back pipe; the 4-entry
//   queue keeps taking beats until it fills, then in_tready drops
`default_nettype none
module lens_distortion_scale_top import lds_pkg::*; #(
  parameter int NUM_SEGMENTS = 11,
  parameter int FRAC_BITS    = 24
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // [3:0] coef_index, [35:4] coef_value, [66:36] radius_sq, [71:67] zero
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // [0] mode
  input  logic                   in_tuser,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // [31:0] scale
  output logic [OUT_TDATA_W-1:0] out_tdata,
  // [0] overflow
  output logic                   out_tuser,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [1:0]             cfg_index,
  input  logic [31:0]            cfg_data
);

  // config registers, read live by the back pipe
  logic [1:0]  eq_type_r;
  fix_t        ab_off_r;
  fix_t        ab_slope_r;
  logic [30:0] seg_per_r;
  cfg_t        cfg;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eq_type_r  <= EQ_SPLINE;
      ab_off_r   <= '0;
      ab_slope_r <= '0;
      seg_per_r  <= 31'd167772160;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_EQ_TYPE:  eq_type_r  <= cfg_data[1:0];
        CFG_AB_OFF:   ab_off_r   <= cfg_data;
        CFG_AB_SLOPE: ab_slope_r <= cfg_data;
        CFG_SEG_PER:  seg_per_r  <= cfg_data[30:0];
      endcase
    end
  end

  always_comb begin
    cfg.eq    = eq_type_r;
    cfg.off   = ab_off_r;
    cfg.slope = ab_slope_r;
    cfg.spr   = seg_per_r;
  end

  // queue between the beat classifier and the arithmetic pipe
  item_t q_item;
  logic  q_valid;
  logic  q_pop;
  fix_t  res_scale;

  lds_front #(
    .NUM_SEGMENTS (NUM_SEGMENTS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_item    (q_item),
    .q_valid   (q_valid),
    .q_pop     (q_pop)
  );

  lds_back #(
    .NUM_SEGMENTS (NUM_SEGMENTS),
    .FRAC_BITS    (FRAC_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .q_item    (q_item),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .res_valid (out_tvalid),
    .res_ready (out_tready),
    .res_scale (res_scale),
    .res_ovf   (out_tuser)
  );

  assign out_tdata = res_scale;

endmodule
`default_nettype wire

// File: rtl/lds_front.sv
// front end: beat unpacking, load filtering and the item queue
`default_nettype none
module lds_front import lds_pkg::*; #(
  parameter int NUM_SEGMENTS = 11
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_TDATA_W-1:0] in_tdata,
  input  logic                  in_tuser,
  output item_t                 q_item,
  output logic                  q_valid,
  input  logic                  q_pop
);

  item_t           beat;
  logic            keep;
  logic            push;
  item_t           mem_r [QDEPTH];
  logic [QPW-1:0]  wp_r;
  logic [QPW-1:0]  rp_r;
  logic [QPW:0]    cnt_r;

  always_comb begin
    beat.load = (in_tuser == MODE_LOAD);
    beat.idx  = in_tdata[3:0];
    beat.val  = in_tdata[35:4];
    beat.rsq  = in_tdata[66:36];
  end

  // loads past the table end are taken and dropped
  assign keep = !(beat.load && ({2'b00, beat.idx} >= 6'(NUM_SEGMENTS)));
  assign push = in_tvalid && in_tready && keep;

  assign in_tready = (cnt_r != (QPW+1)'(QDEPTH));
  assign q_valid   = (cnt_r != '0);
  assign q_item    = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= beat;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= wp_r + 1'b1;
      end
      if (q_pop) begin
        rp_r <= rp_r + 1'b1;
      end
      priority if (push && !q_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (!push && q_pop) begin
        cnt_r <= cnt_r - 1'b1;
      end else begin
        cnt_r <= cnt_r;
      end
    end
  end

endmodule
`default_nettype wire

// File: rtl/lds_back.sv
// back end: coefficient table, equation pipeline, divider and output register
`default_nettype none
module lds_back import lds_pkg::*; #(
  parameter int NUM_SEGMENTS = 11,
  parameter int FRAC_BITS    = 24
) (
  input  logic  clk,
  input  logic  rst_n,
  input  cfg_t  cfg,
  input  item_t q_item,
  input  logic  q_valid,
  output logic  q_pop,
  output logic  res_valid,
  input  logic  res_ready,
  output fix_t  res_scale,
  output logic  res_ovf
);

  localparam int                 SEG_W = $clog2(NUM_SEGMENTS);
  localparam int                 DIV_STEPS = 32;
  localparam fix_t               ONE = fix_t'(64'sd1 <<< FRAC_BITS);
  localparam logic signed [63:0] RND = 64'sd1 <<< (FRAC_BITS - 1);
  localparam logic [63:0]        RECIP_NUM = 64'd1 << (2 * FRAC_BITS);

  function automatic satres_t mulq(input fix_t a, input fix_t b);
    logic signed [63:0] p;
    p = a * b;
    p = p + RND;
    return sat64(p >>> FRAC_BITS);
  endfunction

  function automatic satres_t sadd(input fix_t a, input fix_t b);
    return sat64(64'(a) + 64'(b));
  endfunction

  function automatic satres_t ssub(input fix_t a, input fix_t b);
    return sat64(64'(a) - 64'(b));
  endfunction

  function automatic satres_t hdiff(input fix_t a, input fix_t b);
    return sat64((64'(a) - 64'(b) + 64'sd1) >>> 1);
  endfunction

  logic adv;
  assign adv   = !res_valid || res_ready;
  assign q_pop = q_valid && adv;

  logic   vs_r [1:8];
  carry_t car_r [2:8];

  // stage 1: segment position and aberration slope term
  logic       ld1_r;
  logic [3:0] idx1_r;
  fix_t       val1_r;
  fix_t       r1_r;
  satres_t    x1_r;
  satres_t    sl1_r;
  fix_t       r_head;

  assign r_head = fix_t'({1'b0, q_item.rsq});

  always_ff @(posedge clk) begin
    if (adv) begin
      idx1_r <= q_item.idx;
      val1_r <= q_item.val;
      r1_r   <= r_head;
      x1_r   <= mulq(fix_t'({1'b0, cfg.spr}), r_head);
      sl1_r  <= mulq(cfg.slope, r_head);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ld1_r <= 1'b0;
      for (int k = 1; k <= 8; k++) begin
        vs_r[k] <= 1'b0;
      end
    end else if (adv) begin
      ld1_r    <= q_pop && q_item.load;
      vs_r[1]  <= q_pop && !q_item.load;
      vs_r[2]  <= vs_r[1];
      for (int k = 3; k <= 8; k++) begin
        vs_r[k] <= vs_r[k-1];
      end
    end
  end

  // stage 2: segment select, table read, aberration factor
  logic [31:0]      seg_ext;
  logic [SEG_W-1:0] seg_nxt;
  logic [SEG_W-1:0] addr [4];
  fix_t             c2 [4];
  satres_t          fac_nxt;
  logic [SEG_W-1:0] seg2_r;
  fix_t             t2_r;
  logic             ovx2_r;

  always_comb begin
    seg_ext = $unsigned(x1_r.val) >> FRAC_BITS;
    if (seg_ext > 32'(NUM_SEGMENTS - 1)) begin
      seg_nxt = SEG_W'(NUM_SEGMENTS - 1);
    end else begin
      seg_nxt = seg_ext[SEG_W-1:0];
    end
    fac_nxt = sat64(64'(ONE) + 64'(cfg.off) + 64'(sl1_r.val));
  end

  // four banks hold one table; spline reads segment neighbors, else entries 0 to 3
  for (genvar j = 0; j < 4; j++) begin : g_bank
    logic signed [SEG_W+1:0] sa;
    fix_t                    mem [NUM_SEGMENTS];
    fix_t                    rd_r;

    always_comb begin
      sa = $signed({2'b00, seg_nxt}) - (SEG_W+2)'(1) + (SEG_W+2)'(j);
      if (cfg.eq != EQ_SPLINE) begin
        addr[j] = SEG_W'(j);
      end else if (sa < 0) begin
        addr[j] = '0;
      end else if (sa > (SEG_W+2)'(NUM_SEGMENTS - 1)) begin
        addr[j] = SEG_W'(NUM_SEGMENTS - 1);
      end else begin
        addr[j] = sa[SEG_W-1:0];
      end
    end

    always_ff @(posedge clk) begin
      if (adv && ld1_r) begin
        mem[SEG_W'(idx1_r)] <= val1_r;
      end
      if (adv) begin
        rd_r <= mem[addr[j]];
      end
    end

    assign c2[j] = rd_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      seg2_r     <= seg_nxt;
      t2_r       <= x1_r.val - (fix_t'(seg_nxt) <<< FRAC_BITS);
      ovx2_r     <= x1_r.ovf;
      car_r[2].r   <= r1_r;
      car_r[2].fac <= fac_nxt.val;
      car_r[2].ova <= sl1_r.ovf | fac_nxt.ovf;
      for (int k = 3; k <= 8; k++) begin
        car_r[k] <= car_r[k-1];
      end
    end
  end

  // stage 3: hermite end points and tangents, first quartic product
  satres_t m0_nxt, m1_nxt, omt_nxt, a_nxt, qm3_nxt;
  fix_t    p0_nxt, p1_nxt;
  logic    last_nxt;
  fix_t    t3_r, omt3_r, a3_r, p0_3_r, m0_3_r, p1_3_r, m1_3_r;
  logic    last3_r, ovs3_r, ovq3_r;
  fix_t    qm3_r, k0_3_r, k1_3_r, k2_3_r;

  always_comb begin
    last_nxt = (seg2_r == SEG_W'(NUM_SEGMENTS - 1));
    p0_nxt   = c2[1];
    p1_nxt   = c2[2];
    priority if (seg2_r == '0) begin
      p0_nxt = ONE;
      m0_nxt = ssub(c2[2], c2[1]);
      m1_nxt = hdiff(c2[3], c2[1]);
    end else if (seg2_r == SEG_W'(NUM_SEGMENTS - 2)) begin
      m0_nxt = hdiff(c2[2], c2[1]);
      m1_nxt = ssub(c2[2], c2[1]);
    end else if (last_nxt) begin
      m0_nxt = ssub(c2[1], c2[0]);
      m1_nxt = m0_nxt;
    end else begin
      m0_nxt = hdiff(c2[2], c2[0]);
      m1_nxt = hdiff(c2[3], c2[1]);
    end
    omt_nxt = ssub(ONE, t2_r);
    a_nxt   = sat64(64'(ONE) + 64'sd2 * 64'(t2_r));
    qm3_nxt = mulq(car_r[2].r, c2[3]);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      t3_r    <= t2_r;
      omt3_r  <= omt_nxt.val;
      a3_r    <= a_nxt.val;
      p0_3_r  <= p0_nxt;
      m0_3_r  <= m0_nxt.val;
      p1_3_r  <= p1_nxt;
      m1_3_r  <= m1_nxt.val;
      last3_r <= last_nxt;
      ovs3_r  <= ovx2_r | m0_nxt.ovf | m1_nxt.ovf | omt_nxt.ovf | a_nxt.ovf;
      qm3_r   <= qm3_nxt.val;
      ovq3_r  <= qm3_nxt.ovf;
      k0_3_r  <= c2[0];
      k1_3_r  <= c2[1];
      k2_3_r  <= c2[2];
    end
  end

  // stage 4: extrapolated end point, second blend weight, quartic sum
  satres_t p1_nxt4, b_nxt, qa4_nxt;
  fix_t    t4_r, omt4_r, a4_r, p0_4_r, m0_4_r, p1_4_r, m1_4_r, b4_r;
  logic    ovs4_r, ovq4_r;
  fix_t    qa4_r, k0_4_r, k1_4_r;

  always_comb begin
    p1_nxt4 = last3_r ? sadd(p0_3_r, m0_3_r) : satres_t'{1'b0, p1_3_r};
    b_nxt   = sat64(64'(ONE) + 64'sd2 * 64'(omt3_r));
    qa4_nxt = sadd(k2_3_r, qm3_r);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      t4_r   <= t3_r;
      omt4_r <= omt3_r;
      a4_r   <= a3_r;
      p0_4_r <= p0_3_r;
      m0_4_r <= m0_3_r;
      p1_4_r <= p1_nxt4.val;
      m1_4_r <= m1_3_r;
      b4_r   <= b_nxt.val;
      ovs4_r <= ovs3_r | p1_nxt4.ovf | b_nxt.ovf;
      qa4_r  <= qa4_nxt.val;
      ovq4_r <= ovq3_r | qa4_nxt.ovf;
      k0_4_r <= k0_3_r;
      k1_4_r <= k1_3_r;
    end
  end

  // stage 5: weighted points and tangents, second quartic product
  satres_t pa_nxt, mt_nxt, pb_nxt, mo_nxt, qm5_nxt;
  fix_t    pa5_r, mt5_r, pb5_r, mo5_r, t5_r, omt5_r, qm5_r, k0_5_r, k1_5_r;
  logic    ovs5_r, ovq5_r;

  always_comb begin
    pa_nxt  = mulq(p0_4_r, a4_r);
    mt_nxt  = mulq(m0_4_r, t4_r);
    pb_nxt  = mulq(p1_4_r, b4_r);
    mo_nxt  = mulq(m1_4_r, omt4_r);
    qm5_nxt = mulq(car_r[4].r, qa4_r);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pa5_r  <= pa_nxt.val;
      mt5_r  <= mt_nxt.val;
      pb5_r  <= pb_nxt.val;
      mo5_r  <= mo_nxt.val;
      t5_r   <= t4_r;
      omt5_r <= omt4_r;
      ovs5_r <= ovs4_r | pa_nxt.ovf | mt_nxt.ovf | pb_nxt.ovf | mo_nxt.ovf;
      qm5_r  <= qm5_nxt.val;
      ovq5_r <= ovq4_r | qm5_nxt.ovf;
      k0_5_r <= k0_4_r;
      k1_5_r <= k1_4_r;
    end
  end

  // stage 6: left and right cubic factors, quartic sum
  satres_t u_nxt, v_nxt, qa6_nxt;
  fix_t    u6_r, v6_r, t6_r, omt6_r, qa6_r, k0_6_r;
  logic    ovs6_r, ovq6_r;

  always_comb begin
    u_nxt   = sadd(pa5_r, mt5_r);
    v_nxt   = ssub(pb5_r, mo5_r);
    qa6_nxt = sadd(k1_5_r, qm5_r);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      u6_r   <= u_nxt.val;
      v6_r   <= v_nxt.val;
      t6_r   <= t5_r;
      omt6_r <= omt5_r;
      ovs6_r <= ovs5_r | u_nxt.ovf | v_nxt.ovf;
      qa6_r  <= qa6_nxt.val;
      ovq6_r <= ovq5_r | qa6_nxt.ovf;
      k0_6_r <= k0_5_r;
    end
  end

  // stages 7 and 8: two squaring products each side, last quartic step
  satres_t ul_nxt, vr_nxt, qm7_nxt, lf_nxt, rt_nxt, d_nxt;
  fix_t    ul7_r, vr7_r, t7_r, omt7_r, qm7_r, k0_7_r;
  logic    ovs7_r, ovq7_r;
  fix_t    lf8_r, rt8_r, d8_r;
  logic    ovs8_r, ovq8_r;

  always_comb begin
    ul_nxt  = mulq(u6_r, omt6_r);
    vr_nxt  = mulq(v6_r, t6_r);
    qm7_nxt = mulq(car_r[6].r, qa6_r);
    lf_nxt  = mulq(ul7_r, omt7_r);
    rt_nxt  = mulq(vr7_r, t7_r);
    d_nxt   = sadd(k0_7_r, qm7_r);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ul7_r  <= ul_nxt.val;
      vr7_r  <= vr_nxt.val;
      t7_r   <= t6_r;
      omt7_r <= omt6_r;
      ovs7_r <= ovs6_r | ul_nxt.ovf | vr_nxt.ovf;
      qm7_r  <= qm7_nxt.val;
      ovq7_r <= ovq6_r | qm7_nxt.ovf;
      k0_7_r <= k0_6_r;
      lf8_r  <= lf_nxt.val;
      rt8_r  <= rt_nxt.val;
      ovs8_r <= ovs7_r | lf_nxt.ovf | rt_nxt.ovf;
      d8_r   <= d_nxt.val;
      ovq8_r <= ovq7_r | d_nxt.ovf;
    end
  end

  // stage 9: base select and divider setup
  tail_t              tl_r  [0:DIV_STEPS];
  logic [31:0]        rem_r [0:DIV_STEPS];
  logic [31:0]        quo_r [0:DIV_STEPS];
  logic [31:0]        nlo_r [0:DIV_STEPS];
  satres_t            spl_nxt;
  logic signed [32:0] dext;
  logic [31:0]        mag_nxt;
  logic [63:0]        num_nxt;
  tail_t              tl_nxt;

  always_comb begin
    spl_nxt = sadd(lf8_r, rt8_r);
    dext    = 33'(d8_r);
    mag_nxt = d8_r[31] ? 32'(-dext) : 32'(dext);
    num_nxt = RECIP_NUM + 64'(mag_nxt >> 1);
    tl_nxt.vld   = vs_r[8];
    tl_nxt.recip = 1'b0;
    tl_nxt.zero  = (mag_nxt == '0);
    tl_nxt.neg   = d8_r[31];
    tl_nxt.big   = (num_nxt[63:32] >= mag_nxt);
    tl_nxt.mag   = mag_nxt;
    tl_nxt.fac   = car_r[8].fac;
    tl_nxt.ova   = car_r[8].ova;
    unique case (cfg.eq)
      EQ_QUARTIC: begin
        tl_nxt.base = d8_r;
        tl_nxt.bovf = ovq8_r;
      end
      EQ_RECIP: begin
        tl_nxt.base  = '0;
        tl_nxt.bovf  = ovq8_r;
        tl_nxt.recip = 1'b1;
      end
      EQ_SPLINE: begin
        tl_nxt.base = spl_nxt.val;
        tl_nxt.bovf = ovs8_r | spl_nxt.ovf;
      end
      EQ_UNITY: begin
        tl_nxt.base = ONE;
        tl_nxt.bovf = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tl_r[0].vld <= 1'b0;
    end else if (adv) begin
      tl_r[0]  <= tl_nxt;
      rem_r[0] <= num_nxt[63:32];
      quo_r[0] <= '0;
      nlo_r[0] <= num_nxt[31:0];
    end
  end

  // restoring divider, one quotient bit per stage
  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
    logic [32:0] tr;
    logic        ge;

    always_comb begin
      tr = {rem_r[i], nlo_r[i][DIV_STEPS-1-i]};
      ge = (tr >= {1'b0, tl_r[i].mag});
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        tl_r[i+1].vld <= 1'b0;
      end else if (adv) begin
        tl_r[i+1]  <= tl_r[i];
        rem_r[i+1] <= ge ? 32'(tr - {1'b0, tl_r[i].mag}) : tr[31:0];
        quo_r[i+1] <= {quo_r[i][30:0], ge};
        nlo_r[i+1] <= nlo_r[i];
      end
    end
  end

  // final stages: reciprocal clamp, then aberration product into the output register
  logic [32:0]        qs;
  logic signed [63:0] qv;
  satres_t            rq_nxt;
  tail_t              tq;
  logic               vf_r, zf_r, bovff_r, ovaf_r;
  fix_t               basef_r, facf_r;
  satres_t            fin_nxt;
  logic               out_v_r;
  fix_t               out_scale_r;
  logic               out_ovf_r;

  always_comb begin
    tq = tl_r[DIV_STEPS];
    if (tq.big || (quo_r[DIV_STEPS] > 32'h8000_0000)) begin
      qs = 33'h0_8000_0000;
    end else begin
      qs = {1'b0, quo_r[DIV_STEPS]};
    end
    qv = $signed({31'b0, qs});
    if (tq.neg) begin
      qv = -qv;
    end
    rq_nxt  = sat64(qv);
    fin_nxt = mulq(basef_r, facf_r);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      zf_r    <= tq.recip && tq.zero;
      basef_r <= tq.recip ? rq_nxt.val : tq.base;
      bovff_r <= tq.bovf | (tq.recip & rq_nxt.ovf);
      facf_r  <= tq.fac;
      ovaf_r  <= tq.ova;
      if (zf_r) begin
        out_scale_r <= 32'sh7fffffff;
        out_ovf_r   <= 1'b1;
      end else begin
        out_scale_r <= fin_nxt.val;
        out_ovf_r   <= bovff_r | ovaf_r | fin_nxt.ovf;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vf_r    <= 1'b0;
      out_v_r <= 1'b0;
    end else if (adv) begin
      vf_r    <= tq.vld;
      out_v_r <= vf_r;
    end
  end

  assign res_valid = out_v_r;
  assign res_scale = out_scale_r;
  assign res_ovf   = out_ovf_r;

endmodule
`default_nettype wire

// File: rtl/lds_checker.sv
// port-level checker for the lens distortion scale block and its bind
`default_nettype none
`include "lens_distortion_scale_top_defines.svh"
module lds_checker (
  input wire        clk,
  input wire        rst_n,
  input wire        in_tready,
  input wire        out_tvalid,
  input wire        out_tready,
  input wire [31:0] out_tdata,
  input wire        out_tuser,
  input wire        cfg_valid,
  input wire        cfg_ready
);

  // a held result beat keeps its payload
  `LDS_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser))
  // config writes never wait
  `LDS_ASSERT_NOW(a_cfg_rdy, cfg_valid, cfg_ready)
  // reset empties the pipe and the queue
  `LDS_ASSERT_RST(a_rst_out, !rst_n, !out_tvalid)
  `LDS_ASSERT_RST(a_rst_in, !rst_n, in_tready)

endmodule

bind lens_distortion_scale_top lds_checker u_lds_checker (.*);
`default_nettype wire

// File: test/tb_lens_distortion_scale_top.sv
// stream testbench for lens_distortion_scale_top with a self-checking scale predictor
`default_nettype none
module tb_lens_distortion_scale_top;
  import lds_pkg::*;

  localparam int NSEG = 11;
  localparam int FB = 24;
  localparam longint ONE = 64'sd1 << FB;
  localparam longint SMAX = 64'sd2147483647;
  localparam longint SMIN = -64'sd2147483648;
  localparam int DRAIN_CYCLES = 60;

  typedef struct {
    logic        mode;
    logic [3:0]  idx;
    logic [31:0] val;
    logic [30:0] rsq;
  } lens_item_t;

  typedef struct {
    logic [31:0] scale;
    logic        ovf;
  } scale_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_TDATA_W-1:0] in_tdata = '0;
  logic in_tuser = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic out_tuser;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  // pacing knobs, set per phase by the stimulus and hold-off processes
  int idle_pct = 0;
  int stall_pct = 0;
  int phase_no = 0;
  logic hold_rx = 1'b0;

  lens_item_t pending_items[$];
  scale_res_t expected_scales[$];
  int errors = 0;

  // predictor copy of the block state
  longint coef_tab[NSEG];
  logic [1:0] m_eq = EQ_SPLINE;
  longint m_off = 0;
  longint m_slope = 0;
  longint m_spr = 167772160;
  bit sat_flag;

  always #2 clk = ~clk;

  lens_distortion_scale_top i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // ---------------- fixed-point predictor ----------------

  function automatic longint clip(longint v);
    if (v > SMAX) begin
      sat_flag = 1'b1;
      return SMAX;
    end
    if (v < SMIN) begin
      sat_flag = 1'b1;
      return SMIN;
    end
    return v;
  endfunction

  // arithmetic shift floors, so adding half first rounds half up
  function automatic longint rnd_shift(longint v, int s);
    return (v + (64'sd1 << (s - 1))) >>> s;
  endfunction

  function automatic longint qmul(longint a, longint b);
    return clip(rnd_shift(a * b, FB));
  endfunction

  function automatic longint qadd(longint a, longint b);
    return clip(a + b);
  endfunction

  function automatic longint half_diff(longint a, longint b);
    return clip(rnd_shift(a - b, 1));
  endfunction

  function automatic longint poly4(longint r);
    longint acc;
    acc = coef_tab[3];
    acc = qadd(coef_tab[2], qmul(r, acc));
    acc = qadd(coef_tab[1], qmul(r, acc));
    return qadd(coef_tab[0], qmul(r, acc));
  endfunction

  function automatic longint spline_at(longint r);
    longint x, seg, t, p0, m0, p1, m1, omt, a, b, u, v, lft, rgt;
    x = qmul(m_spr, r);
    seg = x >>> FB;
    if (seg > NSEG - 1) seg = NSEG - 1;
    t = x - (seg << FB);
    if (seg == 0) begin
      // first segment starts at unity with slope of the first two knots
      p0 = ONE;
      m0 = qadd(coef_tab[1], -coef_tab[0]);
      p1 = coef_tab[1];
      m1 = half_diff(coef_tab[2], coef_tab[0]);
    end else if (seg == NSEG - 2) begin
      p0 = coef_tab[NSEG-2];
      m0 = half_diff(coef_tab[NSEG-1], coef_tab[NSEG-2]);
      p1 = coef_tab[NSEG-1];
      m1 = qadd(coef_tab[NSEG-1], -coef_tab[NSEG-2]);
    end else if (seg == NSEG - 1) begin
      // straight-line extension past the last knot
      p0 = coef_tab[NSEG-1];
      m0 = qadd(coef_tab[NSEG-1], -coef_tab[NSEG-2]);
      p1 = qadd(p0, m0);
      m1 = m0;
    end else begin
      p0 = coef_tab[seg];
      m0 = half_diff(coef_tab[seg+1], coef_tab[seg-1]);
      p1 = coef_tab[seg+1];
      m1 = half_diff(coef_tab[seg+2], coef_tab[seg]);
    end
    omt = qadd(ONE, -t);
    a = clip(ONE + 2 * t);
    u = qadd(qmul(p0, a), qmul(m0, t));
    lft = qmul(qmul(u, omt), omt);
    b = clip(ONE + 2 * omt);
    v = qadd(qmul(p1, b), -qmul(m1, omt));
    rgt = qmul(qmul(v, t), t);
    return qadd(lft, rgt);
  endfunction

  // applies one accepted item to the predictor, queues the scale it should produce
  function automatic void predict_scale(lens_item_t it);
    longint r, base, d, mag, q, fac;
    scale_res_t res;
    if (it.mode == MODE_LOAD) begin
      if (it.idx < NSEG) coef_tab[it.idx] = longint'($signed(it.val));
      return;
    end
    r = longint'(it.rsq);
    sat_flag = 1'b0;
    case (m_eq)
      EQ_QUARTIC: base = poly4(r);
      EQ_RECIP: begin
        d = poly4(r);
        if (d == 0) begin
          // zero divisor: saturated positive, aberration skipped
          res.scale = 32'h7fffffff;
          res.ovf = 1'b1;
          expected_scales.push_back(res);
          return;
        end
        mag = (d < 0) ? -d : d;
        q = ((64'sd1 << (2 * FB)) + mag / 2) / mag;
        if (q > SMAX + 1) q = SMAX + 1;
        base = clip((d < 0) ? -q : q);
      end
      EQ_SPLINE: base = spline_at(r);
      default: base = ONE;
    endcase
    fac = clip(ONE + m_off + qmul(m_slope, r));
    res.scale = 32'(qmul(base, fac));
    res.ovf = sat_flag;
    expected_scales.push_back(res);
  endfunction

  // ---------------- input driver ----------------

  always @(posedge clk) begin
    if (rst_n) begin
      automatic bit taken = in_tvalid && in_tready;
      if (taken) begin
        predict_scale(pending_items[0]);
        void'(pending_items.pop_front());
      end
      // present the next beat only once the current one is gone
      if (!in_tvalid || taken) begin
        if (pending_items.size() > 0 && $urandom_range(99) >= idle_pct) begin
          in_tvalid <= 1'b1;
          in_tuser <= pending_items[0].mode;
          in_tdata <= {5'b0, pending_items[0].rsq, pending_items[0].val,
                       pending_items[0].idx};
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------- output monitor ----------------

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (expected_scales.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected beat: scale %h ovf %b", out_tdata, out_tuser);
        end else begin
          automatic scale_res_t exp_res = expected_scales.pop_front();
          if (out_tdata !== exp_res.scale || out_tuser !== exp_res.ovf) begin
            errors++;
            if (errors <= 10)
              $display("scale mismatch: expected %h ovf %b, got %h ovf %b",
                       exp_res.scale, exp_res.ovf, out_tdata, out_tuser);
          end
        end
      end
      out_tready <= !hold_rx && ($urandom_range(99) >= stall_pct);
    end
  end

  // long receiver hold-off in the pressure phase so the input queue fills
  initial begin
    wait (phase_no == 4);
    repeat (20) @(posedge clk);
    hold_rx <= 1'b1;
    repeat (400) @(posedge clk);
    hold_rx <= 1'b0;
  end

  // ---------------- stimulus ----------------

  task automatic write_reg(logic [1:0] idx, logic [31:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_EQ_TYPE: m_eq = data[1:0];
      CFG_AB_OFF: m_off = longint'($signed(data));
      CFG_AB_SLOPE: m_slope = longint'($signed(data));
      default: m_spr = longint'(data[30:0]);
    endcase
  endtask

  task automatic set_config(logic [1:0] eq, logic [31:0] off, logic [31:0] slope,
                            logic [31:0] spr);
    write_reg(CFG_EQ_TYPE, {30'b0, eq});
    write_reg(CFG_AB_OFF, off);
    write_reg(CFG_AB_SLOPE, slope);
    write_reg(CFG_SEG_PER, spr);
  endtask

  // lets every queued beat go out and the pipe empty before a config write
  task automatic drain();
    while (pending_items.size() > 0 || in_tvalid || expected_scales.size() > 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic void add_load(int idx, logic [31:0] val);
    lens_item_t it;
    it.mode = MODE_LOAD;
    it.idx = 4'(idx);
    it.val = val;
    it.rsq = 31'($urandom);
    pending_items.push_back(it);
  endfunction

  function automatic void add_eval(logic [30:0] rsq);
    lens_item_t it;
    it.mode = MODE_EVAL;
    it.idx = 4'($urandom);
    it.val = $urandom;
    it.rsq = rsq;
    pending_items.push_back(it);
  endfunction

  // mostly near-unity coefficients, sometimes anything at all
  function automatic logic [31:0] rand_coef();
    if ($urandom_range(3) == 0) return $urandom;
    return 32'h0100_0000 + 32'($signed($urandom_range(0, 32'h0080_0000)) - 32'sh0040_0000);
  endfunction

  function automatic void add_random(int n);
    repeat (n) begin
      if ($urandom_range(9) == 0)
        add_load($urandom_range(15), rand_coef());
      else if ($urandom_range(3) == 0)
        add_eval(31'($urandom));
      else
        add_eval(31'($urandom_range(0, 32'h0140_0000)));
    end
  endfunction

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // phase 0: default spline, directed sweep of knots and extremes
    phase_no = 0;
    set_config(EQ_SPLINE, 32'h0, 32'h0, 32'd167772160);
    for (int k = 0; k < NSEG; k++) add_load(k, 32'h0100_0000 + 32'(k) * 32'h0002_0000);
    add_load(15, 32'hffff_ffff);      // out-of-range slot is dropped
    add_load(10, 32'h7fff_ffff);
    add_load(9, 32'h8000_0000);
    add_eval(31'h0);
    add_eval(31'h7fff_ffff);
    add_eval(31'h0019_999a);          // first knot boundary
    add_eval(31'h0133_3333);          // beyond the table, clamped to the last segment
    add_eval(31'h0180_0000);          // past the last knot
    add_eval(31'h00e6_6666);
    for (int k = 0; k < NSEG; k++) add_load(k, rand_coef());
    add_random(380);
    drain();

    // phase 1: quartic, max segment density, sender gaps
    phase_no = 1;
    idle_pct = 67;
    set_config(EQ_QUARTIC, 32'h0010_0000, 32'hfff0_0000, 32'h7fff_ffff);
    add_eval(31'h0);
    add_eval(31'h7fff_ffff);
    add_random(380);
    drain();

    // phase 2: reciprocal with extreme aberration terms, receiver stalls
    phase_no = 2;
    idle_pct = 0;
    stall_pct = 67;
    set_config(EQ_RECIP, 32'h8000_0000, 32'h7fff_ffff, 32'h0);
    add_load(0, 32'h0);               // zero divisor at r = 0
    add_eval(31'h0);
    add_load(0, 32'h0000_0001);       // tiny divisor saturates
    add_eval(31'h0);
    add_load(0, 32'hffff_ffff);
    add_eval(31'h0);
    add_load(0, 32'h0100_0000);
    add_random(380);
    drain();
    set_config(EQ_RECIP, 32'h0, 32'h0, 32'h0);
    add_random(60);
    drain();

    // phase 3: unity base, random aberration, both sides pausing
    phase_no = 3;
    idle_pct = 32;
    stall_pct = 32;
    set_config(EQ_UNITY, $urandom, $urandom, 32'h0100_0000);
    add_eval(31'h7fff_ffff);
    add_random(330);
    drain();

    // phase 4: spline again under a long output hold-off
    phase_no = 4;
    idle_pct = 0;
    stall_pct = 0;
    set_config(EQ_SPLINE, 32'h0004_0000, 32'hfffe_0000, 32'd167772160);
    add_random(380);
    drain();

    if (errors == 0 && expected_scales.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // run limit
  initial begin
    #2000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
`default_nettype wire

// File: files.f
+incdir+rtl
rtl/lds_pkg.sv
rtl/lds_front.sv
rtl/lds_back.sv
rtl/lens_distortion_scale_top.sv
rtl/lds_checker.sv
test/tb_lens_distortion_scale_top.sv
